/* sv/pds_pkg.sv */
package pds_pkg;

    // Page index width on the request channel
    localparam int IDX_W = 16;

    // Event codes
    localparam logic [2:0] CMD_ALLOC       = 3'd0;
    localparam logic [2:0] CMD_MAP_ADD     = 3'd1;
    localparam logic [2:0] CMD_MAP_DEC     = 3'd2;
    localparam logic [2:0] CMD_FREE_CHECK  = 3'd3;
    localparam logic [2:0] CMD_REUSE_QUERY = 3'd4;
    localparam logic [2:0] CMD_READ_STATE  = 3'd5;
    localparam logic [2:0] CMD_CAS         = 3'd6;

    // Page state codes
    localparam logic [2:0] ST_NULL      = 3'd0;
    localparam logic [2:0] ST_VOLATILE  = 3'd1;
    localparam logic [2:0] ST_FIX       = 3'd2;
    localparam logic [2:0] ST_WATCH     = 3'd3;
    localparam logic [2:0] ST_ENQUE     = 3'd4;
    localparam logic [2:0] ST_WATCH_QUE = 3'd5;
    localparam logic [2:0] ST_CHG       = 3'd6;
    localparam logic [2:0] ST_IDLE      = 3'd7;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [IDX_W-1:0] page_index;
        logic             map_count_nonzero;
        logic             from_tracked_process;
        logic [2:0]       expected_state;
        logic [2:0]       replacement_state;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] prior_state;
        logic       bump_volatile_count;
        logic       tree_insert_request;
        logic       tree_delete_request;
        logic       clear_scan_count;
    } rsp_t;

    typedef enum logic [1:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_LOOKUP,
        CTRL_EXEC
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic lookup;
        logic execute;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
    } dp_status_t;

endpackage

/* sv/page_dedup_state_table.sv */
// Per-page state table for memory deduplication.
//
// Request channel: present req and raise start; the request is taken at a
// rising edge with start high and busy low. Each request is a read-modify-
// write of one packed 64-bit word of page states in a single-port-write RAM.
// Result channel: result_valid pulses for exactly one cycle with result; the
// result is issued after the capture, word lookup and execute/write-back steps.
// The receiver cannot stall the block, so nothing is ever held back on the
// output side. A new request is taken only once the last is written back, as
// set by the reciprocal index split, the registered RAM read and the write-back
// of the same word.
// Configuration: cfg_valid/cfg_ready write tracking_enabled (cfg_data);
// cfg_ready is always high. Write it only while the block is idle.
// Reset: the controller, tracking flag and sweep counter clear; the block then
// sweeps zeros through the table, one word per cycle, holding busy high until
// all DEPTH words are written (4096 words at the default parameters) before
// the first request is taken. Configuration writes are taken during the sweep.
module page_dedup_state_table #(
    parameter int PAGE_COUNT      = 65536,
    parameter int STATE_BITS      = 4,
    parameter int STATES_PER_WORD = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  pds_pkg::req_t req,
    output logic          result_valid,
    output pds_pkg::rsp_t result,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);

    pds_pkg::ctrl_cmd_t  ctrl;
    pds_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    pds_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    pds_datapath #(
        .PAGE_COUNT      (PAGE_COUNT),
        .STATE_BITS      (STATE_BITS),
        .STATES_PER_WORD (STATES_PER_WORD)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .status       (status),
        .req          (req),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

/* sv/pds_ram.sv */
module pds_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/pds_ctrl.sv */
module pds_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  pds_pkg::dp_status_t    status,
    output pds_pkg::ctrl_cmd_t     ctrl,
    output logic                   busy
);

    pds_pkg::ctrl_state_t state_reg;
    pds_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pds_pkg::CTRL_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence: clear sweep after reset, then capture, lookup, execute per request
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            pds_pkg::CTRL_CLEAR:
            begin
                ctrl.clear_en = 1'b1;
                if (status.clear_done)
                begin
                    state_next = pds_pkg::CTRL_IDLE;
                end
            end
            pds_pkg::CTRL_IDLE:
            begin
                if (start)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = pds_pkg::CTRL_LOOKUP;
                end
            end
            pds_pkg::CTRL_LOOKUP:
            begin
                ctrl.lookup = 1'b1;
                state_next  = pds_pkg::CTRL_EXEC;
            end
            pds_pkg::CTRL_EXEC:
            begin
                ctrl.execute = 1'b1;
                state_next   = pds_pkg::CTRL_IDLE;
            end
            default:
            begin
                state_next = pds_pkg::CTRL_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != pds_pkg::CTRL_IDLE);

endmodule

/* sv/pds_datapath.sv */
module pds_datapath #(
    parameter int PAGE_COUNT      = 65536,
    parameter int STATE_BITS      = 4,
    parameter int STATES_PER_WORD = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pds_pkg::ctrl_cmd_t  ctrl,
    output pds_pkg::dp_status_t status,
    input  pds_pkg::req_t       req,
    input  logic                cfg_we,
    input  logic                cfg_data,
    output logic                result_valid,
    output pds_pkg::rsp_t       result
);

    localparam int IDX_W      = pds_pkg::IDX_W;
    localparam int WORD_COUNT = (PAGE_COUNT + STATES_PER_WORD - 1) / STATES_PER_WORD;
    localparam int IDX_WORDS  = ((1 << IDX_W) + STATES_PER_WORD - 1) / STATES_PER_WORD;
    localparam int DEPTH      = (WORD_COUNT < IDX_WORDS) ? WORD_COUNT : IDX_WORDS;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QW         = $clog2(IDX_WORDS);
    localparam int SW         = $clog2(STATES_PER_WORD);
    localparam int RECIP      = (1 << IDX_W) / STATES_PER_WORD;
    localparam int RECIP_W    = $clog2(RECIP + 1);
    localparam int PROD_W     = IDX_W + RECIP_W;
    localparam bit ALL_PAGES  = (PAGE_COUNT >= (1 << IDX_W));
    localparam logic [63:0] ENTRY_MASK = (64'd1 << STATE_BITS) - 64'd1;

    // Configuration
    logic tracking_reg;

    // Request registers
    logic [2:0]       cmd_reg;
    logic [IDX_W-1:0] page_reg;
    logic             mapped_reg;
    logic             tracked_reg;
    logic [2:0]       expected_reg;
    logic [2:0]       replacement_reg;
    logic             in_range_reg;
    logic [QW-1:0]    q_est_reg;

    // Address registers
    logic [AW-1:0]    word_reg;
    logic [5:0]       shift_reg;
    logic             valid_reg;

    // Clear sweep counter
    logic [AW-1:0]    clr_cnt_reg;

    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  rem;
    logic              rem_over;
    logic [QW-1:0]     q_fix;
    logic [SW-1:0]     slot;
    logic [7:0]        slot_end;
    logic [AW-1:0]     word_addr;

    logic [63:0]       rd_data;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [63:0]       ram_wdata;

    logic [STATE_BITS-1:0] cur_full;
    logic [2:0]        cur;
    logic [2:0]        nxt;
    logic              ok;
    logic              ins;
    logic              del;
    logic              clr;
    logic              wr_entry;
    logic [63:0]       mask;

    // Hold the tracking flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tracking_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            tracking_reg <= cfg_data;
        end
    end

    // Estimate word index by reciprocal multiply; low by at most one
    assign prod = PROD_W'(req.page_index) * PROD_W'(RECIP);

    // Capture the request
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg         <= req.cmd;
            page_reg        <= req.page_index;
            mapped_reg      <= req.map_count_nonzero;
            tracked_reg     <= req.from_tracked_process;
            expected_reg    <= req.expected_state;
            replacement_reg <= req.replacement_state;
            in_range_reg    <= ALL_PAGES || (32'(req.page_index) < 32'(PAGE_COUNT));
            q_est_reg       <= prod[IDX_W +: QW];
        end
    end

    // Correct the quotient and find the slot inside the word
    assign rem       = page_reg - IDX_W'(q_est_reg * STATES_PER_WORD);
    assign rem_over  = (rem >= IDX_W'(STATES_PER_WORD));
    assign q_fix     = q_est_reg + QW'(rem_over);
    assign slot      = rem_over ? SW'(rem - IDX_W'(STATES_PER_WORD)) : SW'(rem);
    assign slot_end  = (8'(slot) + 8'd1) * 8'(STATE_BITS);
    assign word_addr = AW'(q_fix);

    always_ff @(posedge clk)
    begin
        if (ctrl.lookup)
        begin
            word_reg  <= word_addr;
            shift_reg <= 6'(slot_end - 8'(STATE_BITS));
            valid_reg <= in_range_reg && (slot_end <= 8'd64);
        end
    end

    // Advance the clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (ctrl.clear_en)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    assign status.clear_done = (clr_cnt_reg == AW'(DEPTH - 1));

    // Entries only ever hold three-bit codes, so the upper bits stay zero
    assign cur_full = STATE_BITS'(rd_data >> shift_reg);
    assign cur      = cur_full[2:0];

    // Apply the transition rule of the event
    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        ins = 1'b0;
        del = 1'b0;
        clr = 1'b0;
        case (cmd_reg)
            pds_pkg::CMD_ALLOC:
            begin
                if (tracking_reg && tracked_reg && (cur == pds_pkg::ST_NULL) && !mapped_reg)
                begin
                    nxt = pds_pkg::ST_VOLATILE;
                    ok  = 1'b1;
                end
            end
            pds_pkg::CMD_MAP_ADD,
            pds_pkg::CMD_MAP_DEC:
            begin
                ok = 1'b1;
                if (cur == pds_pkg::ST_FIX)
                begin
                    ins = (cmd_reg == pds_pkg::CMD_MAP_ADD);
                    del = (cmd_reg == pds_pkg::CMD_MAP_DEC);
                end
                else if (cur == pds_pkg::ST_WATCH)
                begin
                    nxt = pds_pkg::ST_VOLATILE;
                end
                else if (cur inside {pds_pkg::ST_ENQUE, pds_pkg::ST_WATCH_QUE})
                begin
                    nxt = pds_pkg::ST_CHG;
                end
            end
            pds_pkg::CMD_FREE_CHECK:
            begin
                if (cur == pds_pkg::ST_NULL)
                begin
                    ok = 1'b1;
                end
                else if (cur inside {pds_pkg::ST_IDLE, pds_pkg::ST_FIX,
                                     pds_pkg::ST_VOLATILE, pds_pkg::ST_WATCH})
                begin
                    nxt = pds_pkg::ST_NULL;
                    ok  = 1'b1;
                    clr = 1'b1;
                end
                else
                begin
                    nxt = pds_pkg::ST_IDLE;
                    clr = 1'b1;
                end
            end
            pds_pkg::CMD_REUSE_QUERY:
            begin
                if (cur inside {pds_pkg::ST_NULL, pds_pkg::ST_VOLATILE})
                begin
                    ok = 1'b1;
                end
                else if (cur == pds_pkg::ST_WATCH)
                begin
                    nxt = pds_pkg::ST_VOLATILE;
                    ok  = 1'b1;
                end
            end
            pds_pkg::CMD_READ_STATE:
            begin
                ok = tracking_reg;
            end
            pds_pkg::CMD_CAS:
            begin
                if (cur == expected_reg)
                begin
                    nxt = replacement_reg;
                    ok  = 1'b1;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign wr_entry = valid_reg && ((nxt != cur) || ((cmd_reg == pds_pkg::CMD_CAS) && ok));
    assign mask     = ENTRY_MASK << shift_reg;

    // Drive the write port: zeros during the sweep, merged word on an update
    always_comb
    begin
        if (ctrl.clear_en)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = ctrl.execute && wr_entry;
            ram_waddr = word_reg;
            ram_wdata = (rd_data & ~mask) | ((64'(nxt) << shift_reg) & mask);
        end
    end

    pds_ram #(
        .WIDTH (64),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (word_addr),
        .rdata (rd_data)
    );

    // Drive the result; an unaddressable page reports all zeros
    assign result_valid = ctrl.execute;

    always_comb
    begin
        result = '0;
        if (valid_reg)
        begin
            result.ok                  = ok;
            result.prior_state         = ((cmd_reg == pds_pkg::CMD_READ_STATE) && !tracking_reg)
                                         ? pds_pkg::ST_NULL : cur;
            result.bump_volatile_count = wr_entry && (nxt == pds_pkg::ST_VOLATILE);
            result.tree_insert_request = ins;
            result.tree_delete_request = del;
            result.clear_scan_count    = clr;
        end
    end

endmodule
